/* src/lock_order_cycle_checker_top_assert.svh */
// assertion macros for the lock order cycle checker top level
// expects clk and rst_n in the scope of use
`ifndef LOCK_ORDER_CYCLE_CHECKER_TOP_ASSERT_SVH
`define LOCK_ORDER_CYCLE_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define LOC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LOC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/loc_pkg.sv */
// shared widths and parameter defaults for the lock order cycle checker
// no dependencies
`default_nettype none

package loc_pkg;

    localparam int LOCK_SLOTS_DEF   = 64;
    localparam int STACK_DEPTH_DEF  = 16;
    localparam int THREAD_COUNT_DEF = 4;

    localparam int ADDR_W   = 64;
    localparam int THREAD_W = 2;
    localparam int LOCKID_W = 6;
    localparam int MASK_W   = 64;

    typedef enum logic
    {
        CMD_LOCK   = 1'b0,
        CMD_UNLOCK = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

/* src/loc_if.sv */
// request and response channel interfaces of the lock order cycle checker
// depends on loc_pkg
`default_nettype none

interface loc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [loc_pkg::THREAD_W-1:0]  thread_num;
    logic [loc_pkg::ADDR_W-1:0]    mutex_addr;

    modport source (output valid, command, thread_num, mutex_addr, input ready);
    modport sink   (input valid, command, thread_num, mutex_addr, output ready);
endinterface

interface loc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [loc_pkg::LOCKID_W-1:0]  lock_id;
    logic                          table_full;
    logic [loc_pkg::MASK_W-1:0]    conflict_mask;
    logic                          stack_full;
    logic                          removed;

    modport source (output valid, lock_id, table_full, conflict_mask, stack_full, removed,
                    input ready);
    modport sink   (input valid, lock_id, table_full, conflict_mask, stack_full, removed,
                    output ready);
endinterface

`default_nettype wire

/* src/lock_order_cycle_checker_top.sv */
// lock order cycle checker: lock table, order graph and per-thread held stacks
// depends on loc_pkg, loc_if and lock_order_cycle_checker_top_assert.svh
//
// channel  dir  payload
// req      in   command, thread_num, mutex_addr
// rsp      out  lock_id, table_full, conflict_mask, stack_full, removed
//
// one request at a time; a lock searches the table entries up to a match (with an
// allocation step when the address is new), sweeps each node reached in the order graph,
// then visits each held lock, paced by the single read port of each table memory
// an unlock scans the stack entries from the top, then shifts the entries above the match
// rsp is registered, so a new request is taken while a response waits
// reset clears counts and order-row valid bits at once, no clearing pass
`default_nettype none

`include "lock_order_cycle_checker_top_assert.svh"

module lock_order_cycle_checker_top #(
    parameter int LOCK_SLOTS   = loc_pkg::LOCK_SLOTS_DEF,
    parameter int STACK_DEPTH  = loc_pkg::STACK_DEPTH_DEF,
    parameter int THREAD_COUNT = loc_pkg::THREAD_COUNT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    loc_req_if.sink    req,
    loc_rsp_if.source  rsp
);

    localparam int ID_W    = $clog2(LOCK_SLOTS);
    localparam int CNT_W   = $clog2(LOCK_SLOTS + 1);
    localparam int SCNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int IT_W    = (CNT_W > SCNT_W) ? CNT_W : SCNT_W;
    localparam int TIDX_W  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int SM_D    = THREAD_COUNT * STACK_DEPTH;
    localparam int SA_W    = (SM_D > 1) ? $clog2(SM_D) : 1;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_SRCH,
        S_RCH_RD,
        S_RCH_MRG,
        S_H_RD,
        S_H_ER,
        S_H_EW,
        S_PUSH,
        S_U_RD,
        S_U_AR,
        S_U_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    // memories
    logic [loc_pkg::ADDR_W-1:0] addr_mem [LOCK_SLOTS];
    logic [LOCK_SLOTS-1:0]      edge_mem [LOCK_SLOTS];
    logic [ID_W-1:0]            stk_mem  [SM_D];

    logic [loc_pkg::ADDR_W-1:0] addr_rd_reg;
    logic [LOCK_SLOTS-1:0]      edge_rd_reg;
    logic [ID_W-1:0]            stk_rd_reg;

    logic [ID_W-1:0]            addr_raddr;
    logic                       addr_we;
    logic [ID_W-1:0]            addr_waddr;
    logic [ID_W-1:0]            edge_raddr;
    logic                       edge_we;
    logic [ID_W-1:0]            edge_waddr;
    logic [LOCK_SLOTS-1:0]      edge_wdata;
    logic [SA_W-1:0]            stk_raddr;
    logic                       stk_we;
    logic [SA_W-1:0]            stk_waddr;
    logic [ID_W-1:0]            stk_wdata;

    // control and working registers
    state_t                     state_reg;
    logic [TIDX_W-1:0]          th_reg;
    logic [loc_pkg::ADDR_W-1:0] mutex_reg;
    logic [ID_W-1:0]            id_reg;
    logic [ID_W-1:0]            idx_reg;
    logic                       cmp_vld_reg;
    logic [IT_W-1:0]            it_reg;
    logic [SCNT_W-1:0]          n_reg;
    logic [CNT_W-1:0]           lock_cnt_reg;
    logic [SCNT_W-1:0]          held_cnt_reg [THREAD_COUNT];
    logic [LOCK_SLOTS-1:0]      row_vld_reg;
    logic [LOCK_SLOTS-1:0]      seen_reg;
    logic [LOCK_SLOTS-1:0]      done_reg;
    logic [LOCK_SLOTS-1:0]      mask_reg;
    logic                       tfull_reg;
    logic                       sfull_reg;
    logic                       removed_reg;

    logic                       out_valid_reg;
    logic [loc_pkg::LOCKID_W-1:0] out_id_reg;
    logic                       out_tfull_reg;
    logic [loc_pkg::MASK_W-1:0] out_mask_reg;
    logic                       out_sfull_reg;
    logic                       out_removed_reg;

    logic                       in_fire;
    logic                       in_th_ok;
    logic [TIDX_W-1:0]          in_th;
    logic [SA_W-1:0]            stk_base;
    logic [LOCK_SLOTS-1:0]      pend;
    logic                       pend_any;
    logic [ID_W-1:0]            pick;
    logic [LOCK_SLOTS-1:0]      edge_row;
    logic                       out_free;

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign in_th_ok  = (32'(req.thread_num) < THREAD_COUNT);
    assign in_th     = TIDX_W'(req.thread_num);
    assign stk_base  = SA_W'(32'(th_reg) * STACK_DEPTH);
    assign pend      = seen_reg & ~done_reg;
    assign pend_any  = |pend;
    assign edge_row  = row_vld_reg[idx_reg] ? edge_rd_reg : '0;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.lock_id       = out_id_reg;
    assign rsp.table_full    = out_tfull_reg;
    assign rsp.conflict_mask = out_mask_reg;
    assign rsp.stack_full    = out_sfull_reg;
    assign rsp.removed       = out_removed_reg;

    // lowest pending node of the reach sweep
    always_comb
    begin
        pick = '0;
        for (int k = LOCK_SLOTS - 1; k >= 0; k--)
        begin
            if (pend[k])
            begin
                pick = ID_W'(k);
            end
        end
    end

    // memory port control
    always_comb
    begin
        addr_raddr = idx_reg;
        addr_we    = 1'b0;
        addr_waddr = lock_cnt_reg[ID_W-1:0];
        edge_raddr = pick;
        edge_we    = 1'b0;
        edge_waddr = idx_reg;
        edge_wdata = edge_row | (LOCK_SLOTS'(1) << id_reg);
        stk_raddr  = stk_base + SA_W'(it_reg);
        stk_we     = 1'b0;
        stk_waddr  = stk_base + SA_W'(it_reg);
        stk_wdata  = stk_rd_reg;
        unique case (state_reg)
            S_SRCH:
            begin
                addr_raddr = it_reg[ID_W-1:0];
                addr_we    = !(cmp_vld_reg && addr_rd_reg == mutex_reg)
                             && !(IT_W'(lock_cnt_reg) > it_reg) && !cmp_vld_reg
                             && (32'(lock_cnt_reg) < LOCK_SLOTS);
            end
            S_H_ER:
            begin
                edge_raddr = stk_rd_reg;
            end
            S_H_EW:
            begin
                edge_we = 1'b1;
            end
            S_PUSH:
            begin
                stk_waddr = stk_base + SA_W'(n_reg);
                stk_wdata = id_reg;
                stk_we    = (32'(n_reg) < STACK_DEPTH);
            end
            S_U_RD:
            begin
                stk_raddr = stk_base + SA_W'(it_reg - IT_W'(1));
            end
            S_U_AR:
            begin
                addr_raddr = stk_rd_reg;
            end
            S_SH_RD:
            begin
                stk_raddr = stk_base + SA_W'(it_reg + IT_W'(1));
            end
            S_SH_WR:
            begin
                stk_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (addr_we)
        begin
            addr_mem[addr_waddr] <= mutex_reg;
        end
        addr_rd_reg <= addr_mem[addr_raddr];
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rd_reg <= edge_mem[edge_raddr];
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            th_reg          <= '0;
            mutex_reg       <= '0;
            id_reg          <= '0;
            idx_reg         <= '0;
            cmp_vld_reg     <= 1'b0;
            it_reg          <= '0;
            n_reg           <= '0;
            lock_cnt_reg    <= '0;
            for (int t = 0; t < THREAD_COUNT; t++)
            begin
                held_cnt_reg[t] <= '0;
            end
            row_vld_reg     <= '0;
            seen_reg        <= '0;
            done_reg        <= '0;
            mask_reg        <= '0;
            tfull_reg       <= 1'b0;
            sfull_reg       <= 1'b0;
            removed_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_id_reg      <= '0;
            out_tfull_reg   <= 1'b0;
            out_mask_reg    <= '0;
            out_sfull_reg   <= 1'b0;
            out_removed_reg <= 1'b0;
        end
        else
        begin
            if (rsp.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        th_reg      <= in_th;
                        mutex_reg   <= req.mutex_addr;
                        id_reg      <= '0;
                        mask_reg    <= '0;
                        tfull_reg   <= 1'b0;
                        sfull_reg   <= 1'b0;
                        removed_reg <= 1'b0;
                        cmp_vld_reg <= 1'b0;
                        if (!in_th_ok)
                        begin
                            it_reg    <= '0;
                            state_reg <= S_DONE;
                        end
                        else if (req.command == loc_pkg::CMD_LOCK)
                        begin
                            it_reg    <= '0;
                            state_reg <= S_SRCH;
                        end
                        else
                        begin
                            n_reg     <= held_cnt_reg[in_th];
                            it_reg    <= IT_W'(held_cnt_reg[in_th]);
                            state_reg <= S_U_RD;
                        end
                    end
                end
                S_SRCH:
                begin
                    if (cmp_vld_reg && addr_rd_reg == mutex_reg)
                    begin
                        id_reg    <= idx_reg;
                        seen_reg  <= LOCK_SLOTS'(1) << idx_reg;
                        done_reg  <= '0;
                        state_reg <= S_RCH_RD;
                    end
                    else if (IT_W'(lock_cnt_reg) > it_reg)
                    begin
                        idx_reg     <= it_reg[ID_W-1:0];
                        cmp_vld_reg <= 1'b1;
                        it_reg      <= it_reg + IT_W'(1);
                    end
                    else if (cmp_vld_reg)
                    begin
                        cmp_vld_reg <= 1'b0;
                    end
                    else if (32'(lock_cnt_reg) >= LOCK_SLOTS)
                    begin
                        tfull_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        id_reg       <= lock_cnt_reg[ID_W-1:0];
                        seen_reg     <= LOCK_SLOTS'(1) << lock_cnt_reg[ID_W-1:0];
                        done_reg     <= '0;
                        lock_cnt_reg <= lock_cnt_reg + CNT_W'(1);
                        state_reg    <= S_RCH_RD;
                    end
                end
                S_RCH_RD:
                begin
                    if (pend_any)
                    begin
                        idx_reg   <= pick;
                        done_reg  <= done_reg | (LOCK_SLOTS'(1) << pick);
                        state_reg <= S_RCH_MRG;
                    end
                    else
                    begin
                        it_reg    <= '0;
                        n_reg     <= held_cnt_reg[th_reg];
                        state_reg <= S_H_RD;
                    end
                end
                S_RCH_MRG:
                begin
                    seen_reg  <= seen_reg | edge_row;
                    state_reg <= S_RCH_RD;
                end
                S_H_RD:
                begin
                    if (IT_W'(n_reg) > it_reg)
                    begin
                        state_reg <= S_H_ER;
                    end
                    else
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_H_ER:
                begin
                    if (seen_reg[stk_rd_reg])
                    begin
                        mask_reg <= mask_reg | (LOCK_SLOTS'(1) << stk_rd_reg);
                    end
                    idx_reg   <= stk_rd_reg;
                    state_reg <= S_H_EW;
                end
                S_H_EW:
                begin
                    row_vld_reg[idx_reg] <= 1'b1;
                    it_reg               <= it_reg + IT_W'(1);
                    state_reg            <= S_H_RD;
                end
                S_PUSH:
                begin
                    if (32'(n_reg) < STACK_DEPTH)
                    begin
                        held_cnt_reg[th_reg] <= n_reg + SCNT_W'(1);
                    end
                    else
                    begin
                        sfull_reg <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_U_RD:
                begin
                    if (it_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_U_AR;
                    end
                end
                S_U_AR:
                begin
                    state_reg <= S_U_CMP;
                end
                S_U_CMP:
                begin
                    it_reg <= it_reg - IT_W'(1);
                    if (addr_rd_reg == mutex_reg)
                    begin
                        state_reg <= S_SH_RD;
                    end
                    else
                    begin
                        state_reg <= S_U_RD;
                    end
                end
                S_SH_RD:
                begin
                    if (it_reg + IT_W'(1) < IT_W'(n_reg))
                    begin
                        state_reg <= S_SH_WR;
                    end
                    else
                    begin
                        held_cnt_reg[th_reg] <= n_reg - SCNT_W'(1);
                        removed_reg          <= 1'b1;
                        state_reg            <= S_DONE;
                    end
                end
                S_SH_WR:
                begin
                    it_reg    <= it_reg + IT_W'(1);
                    state_reg <= S_SH_RD;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_id_reg      <= loc_pkg::LOCKID_W'(id_reg);
                        out_tfull_reg   <= tfull_reg;
                        out_mask_reg    <= loc_pkg::MASK_W'(mask_reg);
                        out_sfull_reg   <= sfull_reg;
                        out_removed_reg <= removed_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `LOC_ASSERT_IMP(a_tfull_quiet, rsp.valid && rsp.table_full, rsp.lock_id == '0 && rsp.conflict_mask == '0 && !rsp.stack_full && !rsp.removed, "table full response carries data")
    `LOC_ASSERT_IMP(a_unlock_quiet, rsp.valid && rsp.removed, rsp.conflict_mask == '0 && !rsp.table_full && !rsp.stack_full, "unlock response carries lock data")
    `LOC_ASSERT_IMP(a_cnt_bound, 1'b1, 32'(lock_cnt_reg) <= LOCK_SLOTS, "lock table count overflow")
    `LOC_ASSERT_NXT(a_done_loads, state_reg == S_DONE && out_free, rsp.valid && state_reg == S_IDLE, "finished request not delivered")

endmodule

`default_nettype wire

/* dv/tb_lock_order_cycle_checker_top.sv */
// testbench for the lock order cycle checker: directed and random lock/unlock requests,
// each response checked against an in-bench model of lock table, order graph and held stacks
// depends on loc_pkg, loc_if and the lock_order_cycle_checker_top rtl
`default_nettype none

module tb_lock_order_cycle_checker_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = loc_pkg::LOCK_SLOTS_DEF;
    localparam int DEPTH = loc_pkg::STACK_DEPTH_DEF;
    localparam int THREADS = loc_pkg::THREAD_COUNT_DEF;

    typedef struct packed {
        logic [loc_pkg::LOCKID_W-1:0] lock_id;
        logic                         table_full;
        logic [loc_pkg::MASK_W-1:0]   conflict_mask;
        logic                         stack_full;
        logic                         removed;
    } verdict_t;

    logic clk;
    logic rst_n;
    loc_req_if req ();
    loc_rsp_if rsp ();

    lock_order_cycle_checker_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    logic [loc_pkg::ADDR_W-1:0]   mdl_addr [SLOTS];
    int                           mdl_count;
    logic [loc_pkg::MASK_W-1:0]   mdl_edges [SLOTS];
    logic [loc_pkg::LOCKID_W-1:0] mdl_held [THREADS][DEPTH];
    int                           mdl_held_n [THREADS];

    verdict_t expected_verdicts [$];
    bit       failed;
    int       rsp_hold;
    bit       no_idle;
    logic [loc_pkg::ADDR_W-1:0] addr_pool [8];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [loc_pkg::MASK_W-1:0] reachable(int start);
        logic [loc_pkg::MASK_W-1:0] seen, prev;
        seen = '0;
        seen[start] = 1'b1;
        prev = '0;
        while (seen != prev)
        begin
            prev = seen;
            for (int k = 0; k < mdl_count; k++)
                if (prev[k])
                    seen |= mdl_edges[k];
        end
        return seen;
    endfunction

    function automatic verdict_t predict_verdict(loc_pkg::cmd_t cmd, int th,
                                                 logic [loc_pkg::ADDR_W-1:0] addr);
        verdict_t v;
        int id, n, p;
        bit found;
        logic [loc_pkg::MASK_W-1:0] r;
        v = '0;
        n = mdl_held_n[th];
        found = 1'b0;
        id = 0;
        if (cmd == loc_pkg::CMD_LOCK)
        begin
            for (int i = 0; i < mdl_count; i++)
                if (!found && mdl_addr[i] == addr)
                begin
                    id = i;
                    found = 1'b1;
                end
            if (!found)
            begin
                if (mdl_count >= SLOTS)
                begin
                    v.table_full = 1'b1;
                    return v;
                end
                id = mdl_count;
                mdl_addr[id] = addr;
                mdl_count++;
            end
            r = reachable(id);
            for (int i = 0; i < n; i++)
            begin
                p = int'(mdl_held[th][i]);
                if (r[p])
                    v.conflict_mask[p] = 1'b1;
                mdl_edges[p][id] = 1'b1;
            end
            if (n < DEPTH)
            begin
                mdl_held[th][n] = loc_pkg::LOCKID_W'(id);
                mdl_held_n[th] = n + 1;
            end
            else
                v.stack_full = 1'b1;
            v.lock_id = loc_pkg::LOCKID_W'(id);
        end
        else
        begin
            for (int i = n; i > 0; i--)
                if (mdl_addr[mdl_held[th][i-1]] == addr)
                begin
                    for (int j = i - 1; j + 1 < n; j++)
                        mdl_held[th][j] = mdl_held[th][j+1];
                    mdl_held_n[th] = n - 1;
                    v.removed = 1'b1;
                    break;
                end
        end
        return v;
    endfunction

    task automatic send_request(loc_pkg::cmd_t cmd, int th, logic [loc_pkg::ADDR_W-1:0] addr);
        while (!no_idle && $urandom_range(99) < 22)
            @(posedge clk);
        req.valid      <= 1'b1;
        req.command    <= cmd;
        req.thread_num <= loc_pkg::THREAD_W'(th);
        req.mutex_addr <= addr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expected_verdicts.push_back(predict_verdict(cmd, th, addr));
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // response side: random stalls, or a long counted hold-off
    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= no_idle || ($urandom_range(99) >= 22);
        end
    end

    initial
    begin
        verdict_t want, got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                got = '{rsp.lock_id, rsp.table_full, rsp.conflict_mask, rsp.stack_full,
                        rsp.removed};
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t unexpected response %p", $time, got);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t mismatch expected %p actual %p", $time, want, got);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_request(loc_pkg::CMD_UNLOCK, 0, 64'h0);
        send_request(loc_pkg::CMD_LOCK, 0, 64'h0);
        send_request(loc_pkg::CMD_LOCK, 0, '1);
        send_request(loc_pkg::CMD_LOCK, 1, '1);
        send_request(loc_pkg::CMD_LOCK, 1, 64'h0);
        send_request(loc_pkg::CMD_LOCK, 1, 64'h0);
        send_request(loc_pkg::CMD_UNLOCK, 1, 64'h0);
        send_request(loc_pkg::CMD_UNLOCK, 1, 64'h0);
        send_request(loc_pkg::CMD_UNLOCK, 1, 64'h1234);
        send_request(loc_pkg::CMD_UNLOCK, 0, '1);
        for (int i = 0; i < DEPTH + 1; i++)
            send_request(loc_pkg::CMD_LOCK, 3, 64'h100 + i);
        send_request(loc_pkg::CMD_UNLOCK, 3, 64'h105);
        wait_drained();
    endtask

    // random locks from a shared address pool and unlocks of any held lock, with noise and reversed orders
    task automatic test_random(int count);
        int th;
        for (int i = 0; i < 8; i++)
            addr_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < count; i++)
        begin
            no_idle = (i >= count / 3 && i < count / 2);
            th = $urandom_range(THREADS - 1);
            if ($urandom_range(9) < 2)
                send_request(loc_pkg::cmd_t'($urandom_range(1)), th, {$urandom, $urandom});
            else if ($urandom_range(1) || mdl_held_n[th] == 0)
                send_request(loc_pkg::CMD_LOCK, th, addr_pool[$urandom_range(7)]);
            else
                send_request(loc_pkg::CMD_UNLOCK, th,
                             mdl_addr[mdl_held[th][$urandom_range(mdl_held_n[th] - 1)]]);
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_backpressure();
        rsp_hold = 400;
        for (int i = 0; i < 6; i++)
            send_request(loc_pkg::CMD_LOCK, i % THREADS, addr_pool[i]);
        wait_drained();
        for (int i = 0; i < 6; i++)
            send_request(loc_pkg::CMD_UNLOCK, i % THREADS, addr_pool[i]);
        wait_drained();
    endtask

    task automatic test_table_full();
        while (mdl_count < SLOTS)
            send_request(loc_pkg::CMD_LOCK, 2, {$urandom, $urandom});
        send_request(loc_pkg::CMD_LOCK, 2, 64'hdead_beef_0000_0001);
        send_request(loc_pkg::CMD_LOCK, 1, '1);
        send_request(loc_pkg::CMD_UNLOCK, 2, 64'hdead_beef_0000_0001);
        test_random(300);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.command = loc_pkg::CMD_LOCK;
        req.thread_num = '0;
        req.mutex_addr = '0;
        failed = 1'b0;
        rsp_hold = 0;
        no_idle = 1'b0;
        mdl_count = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            mdl_edges[i] = '0;
            mdl_addr[i] = '0;
        end
        for (int t = 0; t < THREADS; t++)
            mdl_held_n[t] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(900);
        test_backpressure();
        test_table_full();
        repeat (300) @(posedge clk);
        if (!failed && expected_verdicts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire

/* lock_order_cycle_checker_top.f */
+incdir+src
src/loc_pkg.sv
src/loc_if.sv
src/lock_order_cycle_checker_top.sv
dv/tb_lock_order_cycle_checker_top.sv
